### design/cmapi_pkg.sv
// Shared constants, types and breakpoint table for the colormap interpolation lookup.
`default_nettype none

package cmapi_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int MAX_STOPS   = 8;
    localparam int LEVEL_W     = FRAC_BITS + 2;
    localparam int ONE         = 1 << FRAC_BITS;
    localparam int HALF        = ONE / 2;
    localparam int CH_W        = 8;
    localparam int STOP_W      = 3 * CH_W;
    localparam int CFG_DATA_W  = 2 * STOP_W;
    localparam int CFG_INDEX_W = 3;
    localparam int COUNT_W     = 4;
    localparam int STOP_IDX_W  = $clog2(MAX_STOPS);
    localparam int ROW_COUNT   = MAX_STOPS / 2;
    localparam int ROW_W       = STOP_IDX_W - 1;
    localparam int N_CODE_W    = 3;
    localparam int N_CODE_MAX  = MAX_STOPS - 2;
    localparam int DIV_STAGES  = 4;
    localparam int DIV_STEPS   = FRAC_BITS / DIV_STAGES;
    localparam int PROD_W      = (CH_W + 1) + (FRAC_BITS + 2);

    typedef logic [FRAC_BITS:0] frac_t;
    typedef logic [N_CODE_W-1:0] n_code_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_STOP_COUNT = 3'd0,
        CFG_STOPS_0_1  = 3'd1,
        CFG_STOPS_2_3  = 3'd2,
        CFG_STOPS_4_5  = 3'd3,
        CFG_STOPS_6_7  = 3'd4
    } cfg_index_e;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } color_t;

    // one row of the stop store: an even stop and the odd stop after it
    typedef struct packed {
        logic             we;
        logic [ROW_W-1:0] row;
        color_t           even;
        color_t           odd;
    } stop_wr_t;

    typedef struct packed {
        logic                 full;
        logic [FRAC_BITS-1:0] q;
        frac_t                rem;
        frac_t                w;
        color_t               c1;
        color_t               c2;
        logic                 clamped;
    } div_word_t;

    typedef struct packed {
        color_t color;
        logic   clamped;
    } pix_t;

    // Breakpoints per stop count (row = count - 2); the last one of each row sits at 1.0.
    localparam frac_t BP_TABLE [0:N_CODE_MAX][0:MAX_STOPS-1] = '{
        '{frac_t'(0), frac_t'(ONE), frac_t'(ONE), frac_t'(ONE),
          frac_t'(ONE), frac_t'(ONE), frac_t'(ONE), frac_t'(ONE)},
        '{frac_t'(0), frac_t'(ONE / 3), frac_t'(ONE), frac_t'(ONE),
          frac_t'(ONE), frac_t'(ONE), frac_t'(ONE), frac_t'(ONE)},
        '{frac_t'(0), frac_t'(ONE / 4), frac_t'(2 * ONE / 4), frac_t'(ONE),
          frac_t'(ONE), frac_t'(ONE), frac_t'(ONE), frac_t'(ONE)},
        '{frac_t'(0), frac_t'(ONE / 5), frac_t'(2 * ONE / 5), frac_t'(3 * ONE / 5),
          frac_t'(ONE), frac_t'(ONE), frac_t'(ONE), frac_t'(ONE)},
        '{frac_t'(0), frac_t'(ONE / 6), frac_t'(2 * ONE / 6), frac_t'(3 * ONE / 6),
          frac_t'(4 * ONE / 6), frac_t'(ONE), frac_t'(ONE), frac_t'(ONE)},
        '{frac_t'(0), frac_t'(ONE / 7), frac_t'(2 * ONE / 7), frac_t'(3 * ONE / 7),
          frac_t'(4 * ONE / 7), frac_t'(5 * ONE / 7), frac_t'(ONE), frac_t'(ONE)},
        '{frac_t'(0), frac_t'(ONE / 8), frac_t'(2 * ONE / 8), frac_t'(3 * ONE / 8),
          frac_t'(4 * ONE / 8), frac_t'(5 * ONE / 8), frac_t'(6 * ONE / 8), frac_t'(ONE)}
    };

endpackage

`default_nettype wire

### design/cmapi_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cmapi_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### design/cmapi_segment.sv
// Clamp, segment search, divider setup and stop store read (two pipeline stages).
`default_nettype none

module cmapi_segment
    import cmapi_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  n_code_t                   n_code,
    input  stop_wr_t                  stop_wr,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [LEVEL_W-1:0] level,
    output logic                      out_valid,
    input  logic                      out_ready,
    output div_word_t                 out_word
);

    // stage A
    logic                   a_ready;
    logic                   a_valid_reg;
    frac_t                  v_next;
    frac_t                  v_reg;
    logic                   a_clamped_next;
    logic                   a_clamped_reg;
    logic [MAX_STOPS-1:1]   le_next;
    logic [MAX_STOPS-1:1]   le_reg;

    // stage B
    logic                   b_ready;
    logic                   b_valid_reg;
    logic [STOP_IDX_W-1:0]  j;
    logic [STOP_IDX_W-1:0]  jm1;
    frac_t                  lo;
    frac_t                  hi;
    frac_t                  d;
    frac_t                  w_next;
    logic                   full_next;
    logic [ROW_W-1:0]       even_addr;
    logic [ROW_W-1:0]       odd_addr;
    logic                   b_full_reg;
    frac_t                  b_rem_reg;
    frac_t                  b_w_reg;
    logic                   b_clamped_reg;
    logic                   b_swap_reg;
    logic                   b_even_ok_reg;
    logic                   b_odd_ok_reg;

    logic [ROW_COUNT-1:0]   row_valid_reg;
    logic [STOP_W-1:0]      even_rdata;
    logic [STOP_W-1:0]      odd_rdata;
    color_t                 even_c;
    color_t                 odd_c;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb
    begin
        a_clamped_next = 1'b0;
        priority if (level[LEVEL_W-1])
        begin
            v_next         = '0;
            a_clamped_next = 1'b1;
        end
        else if (frac_t'(level[LEVEL_W-2:0]) > frac_t'(ONE))
        begin
            v_next         = frac_t'(ONE);
            a_clamped_next = 1'b1;
        end
        else
        begin
            v_next = frac_t'(level[LEVEL_W-2:0]);
        end
        for (int i = 1; i < MAX_STOPS; i++)
        begin
            le_next[i] = (v_next <= BP_TABLE[n_code][i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            row_valid_reg <= '0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (stop_wr.we)
            begin
                row_valid_reg[stop_wr.row] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready)
        begin
            v_reg         <= v_next;
            a_clamped_reg <= a_clamped_next;
            le_reg        <= le_next;
        end
    end

    // The last breakpoint always passes, so the lowest passing one ends the segment.
    always_comb
    begin
        j = STOP_IDX_W'(MAX_STOPS - 1);
        for (int i = MAX_STOPS - 1; i >= 1; i--)
        begin
            if (le_reg[i])
            begin
                j = STOP_IDX_W'(i);
            end
        end
        jm1       = j - STOP_IDX_W'(1);
        lo        = BP_TABLE[n_code][jm1];
        hi        = BP_TABLE[n_code][j];
        d         = v_reg - lo;
        w_next    = hi - lo;
        full_next = (d == w_next);
        even_addr = j[0] ? jm1[STOP_IDX_W-1:1] : j[STOP_IDX_W-1:1];
        odd_addr  = j[0] ? j[STOP_IDX_W-1:1] : jm1[STOP_IDX_W-1:1];
    end

    always_ff @(posedge clk)
    begin
        if (b_ready)
        begin
            b_full_reg    <= full_next;
            b_rem_reg     <= full_next ? '0 : d;
            b_w_reg       <= w_next;
            b_clamped_reg <= a_clamped_reg;
            b_swap_reg    <= !j[0];
            b_even_ok_reg <= row_valid_reg[even_addr];
            b_odd_ok_reg  <= row_valid_reg[odd_addr];
        end
    end

    cmapi_ram #(
        .WIDTH (STOP_W),
        .DEPTH (ROW_COUNT)
    ) u_even_ram (
        .clk   (clk),
        .we    (stop_wr.we),
        .waddr (stop_wr.row),
        .wdata (stop_wr.even),
        .re    (b_ready),
        .raddr (even_addr),
        .rdata (even_rdata)
    );

    cmapi_ram #(
        .WIDTH (STOP_W),
        .DEPTH (ROW_COUNT)
    ) u_odd_ram (
        .clk   (clk),
        .we    (stop_wr.we),
        .waddr (stop_wr.row),
        .wdata (stop_wr.odd),
        .re    (b_ready),
        .raddr (odd_addr),
        .rdata (odd_rdata)
    );

    // rows never written read as black
    assign even_c = b_even_ok_reg ? color_t'(even_rdata) : '0;
    assign odd_c  = b_odd_ok_reg  ? color_t'(odd_rdata)  : '0;

    always_comb
    begin
        out_word.full    = b_full_reg;
        out_word.q       = '0;
        out_word.rem     = b_rem_reg;
        out_word.w       = b_w_reg;
        out_word.c1      = b_swap_reg ? odd_c : even_c;
        out_word.c2      = b_swap_reg ? even_c : odd_c;
        out_word.clamped = b_clamped_reg;
    end

    assign out_valid = b_valid_reg;

    a_rem_below_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.rem < out_word.w))
        else $error("segment remainder not below segment width");

endmodule

`default_nettype wire

### design/cmapi_div_stage.sv
// One stage of the restoring divider that forms the segment scale.
`default_nettype none

module cmapi_div_stage
    import cmapi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  div_word_t in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output div_word_t out_word
);

    logic      valid_reg;
    div_word_t word_reg;
    div_word_t word_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        logic [FRAC_BITS+1:0] rem2;
        logic                 take;
        word_next = in_word;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            rem2 = {word_next.rem, 1'b0};
            take = (rem2 >= {1'b0, word_next.w});
            word_next.q   = {word_next.q[FRAC_BITS-2:0], take};
            word_next.rem = take ? frac_t'(rem2 - {1'b0, word_next.w}) : frac_t'(rem2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    a_full_has_no_low_bits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.full |-> (out_word.q == '0) && (out_word.rem == '0))
        else $error("full scale word carries low quotient bits");

    a_stage_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.rem < out_word.w))
        else $error("divider remainder escaped its bound");

endmodule

`default_nettype wire

### design/cmapi_blend.sv
// Channel blend: multiply stage, then round and output register.
`default_nettype none

module cmapi_blend
    import cmapi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  div_word_t in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output pix_t      out_pix
);

    logic                     m_ready;
    logic                     m_valid_reg;
    logic signed [PROD_W-1:0] m_prod_red_reg;
    logic signed [PROD_W-1:0] m_prod_green_reg;
    logic signed [PROD_W-1:0] m_prod_blue_reg;
    color_t                   m_c1_reg;
    logic                     m_clamped_reg;
    frac_t                    scale;
    logic                     o_ready;
    logic                     o_valid_reg;
    pix_t                     o_pix_reg;
    pix_t                     o_pix_next;

    // (c2 - c1) * s, so that c1*(1-s) + c2*s = c1*ONE + (c2 - c1)*s
    function automatic logic signed [PROD_W-1:0] ch_prod(
        input logic [CH_W-1:0] c1,
        input logic [CH_W-1:0] c2,
        input frac_t           s
    );
        logic signed [CH_W:0]        diff;
        logic signed [FRAC_BITS+1:0] sc;
        logic signed [PROD_W-1:0]    prod;
        diff = $signed({1'b0, c2}) - $signed({1'b0, c1});
        sc   = $signed({1'b0, s});
        prod = diff * sc;
        return prod;
    endfunction

    function automatic logic [CH_W-1:0] ch_round(
        input logic [CH_W-1:0]        c1,
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [PROD_W-1:0] base;
        logic signed [PROD_W-1:0] acc;
        base = $signed({{(PROD_W - CH_W - FRAC_BITS){1'b0}}, c1, {FRAC_BITS{1'b0}}});
        acc  = base + prod + $signed(PROD_W'(HALF));
        return acc[FRAC_BITS +: CH_W];
    endfunction

    assign o_ready  = !o_valid_reg || out_ready;
    assign m_ready  = !m_valid_reg || o_ready;
    assign in_ready = m_ready;
    assign scale    = {in_word.full, in_word.q};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_ready)
            begin
                m_valid_reg <= in_valid;
            end
            if (o_ready)
            begin
                o_valid_reg <= m_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_ready)
        begin
            m_prod_red_reg   <= ch_prod(in_word.c1.red, in_word.c2.red, scale);
            m_prod_green_reg <= ch_prod(in_word.c1.green, in_word.c2.green, scale);
            m_prod_blue_reg  <= ch_prod(in_word.c1.blue, in_word.c2.blue, scale);
            m_c1_reg         <= in_word.c1;
            m_clamped_reg    <= in_word.clamped;
        end
    end

    always_comb
    begin
        o_pix_next.color.red   = ch_round(m_c1_reg.red, m_prod_red_reg);
        o_pix_next.color.green = ch_round(m_c1_reg.green, m_prod_green_reg);
        o_pix_next.color.blue  = ch_round(m_c1_reg.blue, m_prod_blue_reg);
        o_pix_next.clamped     = m_clamped_reg;
    end

    always_ff @(posedge clk)
    begin
        if (o_ready)
        begin
            o_pix_reg <= o_pix_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_pix   = o_pix_reg;

endmodule

`default_nettype wire

### design/colormap_interpolate_lookup.sv
// Top level of the piecewise-linear colormap lookup: config registers and pipeline.
//
// Maps a signed Q2.16 level to an RGB colour by linear interpolation between 2 to 8
// configured colour stops; levels below 0 or above 1.0 are clamped and flagged.
// One level is taken every clock unless an output stall backs up the pipe. Each
// result reaches the output register through eight register stages, the first
// loaded by the edge that accepts its level: two for clamp, segment search and
// stop store read, four for the divider that forms the scale (four quotient bits
// per stage), two for the channel multiply and the rounding into the output
// register. Every stage has its own valid bit and ready, so a stall at the output
// holds the words in place while empty stages still fill. Config writes land at
// once; stops read as black until written, with no clearing pass after reset.
`default_nettype none

module colormap_interpolate_lookup
    import cmapi_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [LEVEL_W-1:0] level,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [CH_W-1:0]           red_out,
    output logic [CH_W-1:0]           green_out,
    output logic [CH_W-1:0]           blue_out,
    output logic                      clamped
);

    n_code_t              n_code_reg;
    n_code_t              n_code_next;
    logic [COUNT_W-1:0]   count;
    stop_wr_t             stop_wr;

    logic                 div_valid [0:DIV_STAGES];
    logic                 div_ready [0:DIV_STAGES];
    div_word_t            div_word  [0:DIV_STAGES];
    pix_t                 out_pix;

    always_comb
    begin
        count        = cfg_data[COUNT_W-1:0];
        n_code_next  = n_code_reg;
        stop_wr.we   = 1'b0;
        stop_wr.row  = '0;
        stop_wr.even = color_t'(cfg_data[STOP_W-1:0]);
        stop_wr.odd  = color_t'(cfg_data[CFG_DATA_W-1:STOP_W]);
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_STOP_COUNT:
                begin
                    priority if (count < COUNT_W'(2))
                    begin
                        n_code_next = '0;
                    end
                    else if (count > COUNT_W'(MAX_STOPS))
                    begin
                        n_code_next = n_code_t'(N_CODE_MAX);
                    end
                    else
                    begin
                        n_code_next = n_code_t'(count - COUNT_W'(2));
                    end
                end
                CFG_STOPS_0_1:
                begin
                    stop_wr.we  = 1'b1;
                    stop_wr.row = ROW_W'(0);
                end
                CFG_STOPS_2_3:
                begin
                    stop_wr.we  = 1'b1;
                    stop_wr.row = ROW_W'(1);
                end
                CFG_STOPS_4_5:
                begin
                    stop_wr.we  = 1'b1;
                    stop_wr.row = ROW_W'(2);
                end
                CFG_STOPS_6_7:
                begin
                    stop_wr.we  = 1'b1;
                    stop_wr.row = ROW_W'(3);
                end
                default:
                begin
                    // drop writes to unknown indexes
                    stop_wr.we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_code_reg <= '0;
        end
        else
        begin
            n_code_reg <= n_code_next;
        end
    end

    cmapi_segment u_segment (
        .clk       (clk),
        .rst_n     (rst_n),
        .n_code    (n_code_reg),
        .stop_wr   (stop_wr),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .level     (level),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .out_word  (div_word[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        cmapi_div_stage u_div_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[g]),
            .in_ready  (div_ready[g]),
            .in_word   (div_word[g]),
            .out_valid (div_valid[g+1]),
            .out_ready (div_ready[g+1]),
            .out_word  (div_word[g+1])
        );
    end

    cmapi_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid[DIV_STAGES]),
        .in_ready  (div_ready[DIV_STAGES]),
        .in_word   (div_word[DIV_STAGES]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_pix   (out_pix)
    );

    assign red_out   = out_pix.color.red;
    assign green_out = out_pix.color.green;
    assign blue_out  = out_pix.color.blue;
    assign clamped   = out_pix.clamped;

    a_empty_output_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input held off while the output register is empty");

    a_stop_code_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        n_code_reg <= n_code_t'(N_CODE_MAX))
        else $error("stop count code beyond the breakpoint table");

endmodule

`default_nettype wire

### bench/colormap_pixel_checker.sv
// Watches the colormap lookup ports, predicts every pixel and compares the results.
`timescale 1ns / 1ps

module colormap_pixel_checker
    import cmapi_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic signed [LEVEL_W-1:0] level,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [CH_W-1:0]           red_out,
    input  logic [CH_W-1:0]           green_out,
    input  logic [CH_W-1:0]           blue_out,
    input  logic                      clamped,
    output int                        errors,
    output int                        pending,
    output int                        pixels_checked,
    output int                        clamped_checked
);

    localparam int REPORT_LIMIT = 50;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] lv;
        pix_t                      px;
    } expected_pixel_t;

    logic [COUNT_W-1:0] stop_count_q;
    color_t             stop_colors [0:MAX_STOPS-1];
    expected_pixel_t    expected_pixels [$];

    initial errors = 0;

    task automatic report_mismatch(input string what, input logic signed [LEVEL_W-1:0] lv,
                                   input int want, input int got);
        errors++;
        if (errors <= REPORT_LIMIT)
            $display("%0t: %s for level %0d: expected 0x%0h, got 0x%0h",
                     $time, what, lv, want, got);
    endtask

    // breakpoint i of n stops; the last one sits at 1.0
    function automatic longint unsigned knot_at(input longint unsigned i,
                                                input longint unsigned n);
        if (i >= n - 1)
            return ONE;
        return (i * ONE) / n;
    endfunction

    function automatic logic [CH_W-1:0] mix_channel(input logic [CH_W-1:0] a,
                                                    input logic [CH_W-1:0] b,
                                                    input longint unsigned s);
        longint unsigned acc;
        acc = longint'(a) * (ONE - s) + longint'(b) * s + HALF;
        acc = acc >> FRAC_BITS;
        return acc[CH_W-1:0];
    endfunction

    function automatic pix_t predict_pixel(input logic signed [LEVEL_W-1:0] lv);
        longint unsigned pos, n, seg, lo, hi, scale;
        int              i;
        color_t          c1, c2;
        pix_t            px;
        px.clamped = 1'b0;
        if (lv < 0) begin
            pos        = 0;
            px.clamped = 1'b1;
        end
        else if (lv > ONE) begin
            pos        = ONE;
            px.clamped = 1'b1;
        end
        else begin
            pos = longint'(lv);
        end
        n = stop_count_q;
        if (n < 2)
            n = 2;
        if (n > MAX_STOPS)
            n = MAX_STOPS;
        // first breakpoint at or above the level ends the segment
        seg = n - 1;
        for (i = int'(n) - 1; i >= 1; i--)
            if (pos <= knot_at(i, n))
                seg = i;
        lo    = knot_at(seg - 1, n);
        hi    = knot_at(seg, n);
        scale = ((pos - lo) << FRAC_BITS) / (hi - lo);
        if (scale > ONE)
            scale = ONE;
        c1 = stop_colors[seg - 1];
        c2 = stop_colors[seg];
        px.color.red   = mix_channel(c1.red, c2.red, scale);
        px.color.green = mix_channel(c1.green, c2.green, scale);
        px.color.blue  = mix_channel(c1.blue, c2.blue, scale);
        return px;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        expected_pixel_t want;
        int              k;
        if (!rst_n) begin
            stop_count_q = 4'd2;
            for (k = 0; k < MAX_STOPS; k++)
                stop_colors[k] = '0;
            expected_pixels.delete();
            pending         = 0;
            pixels_checked  = 0;
            clamped_checked = 0;
        end
        else begin
            if (cfg_write) begin
                case (cfg_index_e'(cfg_index))
                    CFG_STOP_COUNT: stop_count_q = cfg_data[COUNT_W-1:0];
                    CFG_STOPS_0_1, CFG_STOPS_2_3, CFG_STOPS_4_5, CFG_STOPS_6_7:
                    begin
                        k = 2 * (cfg_index - CFG_STOPS_0_1);
                        stop_colors[k]     = cfg_data[STOP_W-1:0];
                        stop_colors[k + 1] = cfg_data[CFG_DATA_W-1:STOP_W];
                    end
                    default: ;  // drop writes to unused indexes
                endcase
            end
            if (in_valid && in_ready) begin
                want.lv = level;
                want.px = predict_pixel(level);
                expected_pixels = {expected_pixels, want};
            end
            if (out_valid && out_ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("word with nothing pending", '0, 0,
                                    {red_out, green_out, blue_out, clamped});
                end
                else begin
                    want = expected_pixels.pop_front();
                    if (red_out !== want.px.color.red)
                        report_mismatch("red_out", want.lv, want.px.color.red, red_out);
                    if (green_out !== want.px.color.green)
                        report_mismatch("green_out", want.lv, want.px.color.green, green_out);
                    if (blue_out !== want.px.color.blue)
                        report_mismatch("blue_out", want.lv, want.px.color.blue, blue_out);
                    if (clamped !== want.px.clamped)
                        report_mismatch("clamped", want.lv, want.px.clamped, clamped);
                    pixels_checked++;
                    if (want.px.clamped)
                        clamped_checked++;
                end
            end
            pending = expected_pixels.size();
        end
    end

endmodule

### bench/tb_colormap_interpolate_lookup.sv
// Stimulus and verdict for the colormap lookup; checking lives in colormap_pixel_checker.
`timescale 1ns / 1ps

module tb_colormap_interpolate_lookup
    import cmapi_pkg::*;
;

    localparam int RANDOM_ITEMS = 725;
    localparam int PIPE_LATENCY = 8;
    localparam int HOLD_CYCLES  = 150;
    localparam int TIMEOUT_NS   = 4_000_000;
    localparam int LEVEL_MIN    = -(1 << (LEVEL_W - 1));
    localparam int LEVEL_MAX    = (1 << (LEVEL_W - 1)) - 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_UNUSED = CFG_INDEX_W'(CFG_STOPS_6_7 + 1);

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write;
    logic [CFG_INDEX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [LEVEL_W-1:0] level;
    logic                      out_valid;
    logic                      out_ready;
    logic [CH_W-1:0]           red_out;
    logic [CH_W-1:0]           green_out;
    logic [CH_W-1:0]           blue_out;
    logic                      clamped;

    int errors;
    int pending;
    int pixels_checked;
    int clamped_checked;

    bit hold_req;
    bit no_gaps;
    int eff_stops;
    int maps_loaded;

    colormap_interpolate_lookup i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .level     (level),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .clamped   (clamped)
    );

    colormap_pixel_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .level           (level),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .red_out         (red_out),
        .green_out       (green_out),
        .blue_out        (blue_out),
        .clamped         (clamped),
        .errors          (errors),
        .pending         (pending),
        .pixels_checked  (pixels_checked),
        .clamped_checked (clamped_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("tb_colormap_interpolate_lookup: done, errors");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_pair();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [COUNT_W-1:0] rand_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 4'd2;
        if (r < 30)
            return 4'd8;
        if (r < 45)
            return COUNT_W'($urandom_range(0, 15));
        return COUNT_W'($urandom_range(2, 8));
    endfunction

    function automatic int rand_level();
        int r, k, knot;
        r = $urandom_range(0, 99);
        if (r < 55)
            return $urandom_range(0, ONE);
        if (r < 75) begin
            // land on or next to a breakpoint of the current map
            k    = $urandom_range(0, eff_stops - 1);
            knot = (k == eff_stops - 1) ? ONE : k * ONE / eff_stops;
            return knot + $urandom_range(0, 6) - 3;
        end
        if (r < 92)
            return $urandom;
        case ($urandom_range(0, 3))
            0:       return LEVEL_MIN;
            1:       return LEVEL_MAX;
            2:       return ONE + 1;
            default: return -1;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    task automatic load_colormap(input logic [COUNT_W-1:0] count,
                                 input logic [ROW_COUNT*CFG_DATA_W-1:0] rows,
                                 input bit junk);
        int                    r;
        logic [CFG_DATA_W-1:0] word;
        for (r = 0; r < ROW_COUNT; r++)
            write_reg(CFG_INDEX_W'(CFG_STOPS_0_1 + r), rows[r*CFG_DATA_W +: CFG_DATA_W]);
        if (junk)
            write_reg(CFG_INDEX_W'($urandom_range(2**CFG_INDEX_W - 1, CFG_FIRST_UNUSED)),
                      rand_pair());
        // random upper bits must not leak into the count
        word               = rand_pair();
        word[COUNT_W-1:0]  = count;
        write_reg(CFG_STOP_COUNT, word);
        cfg_write <= 1'b0;
        eff_stops = (count < 2) ? 2 : (count > MAX_STOPS) ? MAX_STOPS : count;
        maps_loaded++;
    endtask

    task automatic send_level(input int lv);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        level    <= LEVEL_W'(lv);
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // hold the input until every pixel is back, then let the pipe empty
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 2) @(negedge clk);
    endtask

    initial
    begin : receiver
        int   run;
        logic rdy;
        run       = 0;
        rdy       = 1'b1;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
                run      = 0;
            end
            else if (no_gaps) begin
                out_ready <= 1'b1;
            end
            else begin
                if (run == 0) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: begin rdy = 1'b1; run = $urandom_range(1, 20); end
                        5, 6, 7, 8:    begin rdy = 1'b0; run = $urandom_range(1, 3);  end
                        default:       begin rdy = 1'b0; run = $urandom_range(10, 40); end
                    endcase
                end
                run--;
                out_ready <= rdy;
            end
        end
    end

    initial
    begin : stimulus
        int phase, k, n, random_sent;
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        level       = '0;
        hold_req    = 1'b0;
        no_gaps     = 1'b0;
        eff_stops   = 2;
        maps_loaded = 0;
        random_sent = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // two black stops out of reset
        send_level(0);
        send_level(ONE);
        send_level(-1);
        settle();

        load_colormap(4'd8, {24'hFEDCBA, 24'h123456, 24'h808080, 24'h0000FF,
                             24'h00FF00, 24'hFF0000, 24'hFFFFFF, 24'h000000}, 1'b1);
        send_level(LEVEL_MIN);
        send_level(-1);
        send_level(0);
        send_level(1);
        send_level(ONE / 8 - 1);
        send_level(ONE / 8);
        send_level(ONE / 8 + 1);
        send_level(ONE / 2);
        send_level(3 * ONE / 4 + 1);
        send_level(ONE - 1);
        send_level(ONE);
        send_level(ONE + 1);
        send_level(LEVEL_MAX);
        settle();

        // a count below two acts as two
        load_colormap(4'd0, {24'hFEDCBA, 24'h123456, 24'h808080, 24'h0000FF,
                             24'h00FF00, 24'hFF0000, 24'hFFFFFF, 24'h000000}, 1'b0);
        send_level(ONE / 4);
        send_level(ONE / 2);
        send_level(ONE - 1);
        settle();

        // a count above the stop slots acts as eight
        load_colormap(4'd15, {24'hFEDCBA, 24'h123456, 24'h808080, 24'h0000FF,
                              24'h00FF00, 24'hFF0000, 24'hFFFFFF, 24'h000000}, 1'b1);
        send_level(ONE / 8);
        send_level(7 * ONE / 8);
        send_level(ONE);
        settle();

        // three stops: breakpoints that do not divide evenly
        load_colormap(4'd3, {24'hFEDCBA, 24'h123456, 24'h808080, 24'h0000FF,
                             24'h00FF00, 24'hFF0000, 24'hFFFFFF, 24'h000000}, 1'b0);
        send_level(ONE / 3);
        send_level(ONE / 3 + 1);
        send_level(2 * ONE / 3);
        settle();

        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            load_colormap((phase == 0) ? 4'd2 : (phase == 1) ? 4'd8 : rand_count(),
                          {rand_pair(), rand_pair(), rand_pair(), rand_pair()},
                          $urandom_range(0, 2) == 0);
            no_gaps = (phase % 4 == 1);
            // stall the output long enough to back up the whole pipe
            if (phase == 2)
                hold_req = 1'b1;
            n = $urandom_range(40, 80);
            for (k = 0; k < n; k++)
                send_level(rand_level());
            random_sent += n;
            settle();
            no_gaps = 1'b0;
            phase++;
        end

        $display("run covered %0d levels, %0d of them clamped, over %0d colormap settings",
                 pixels_checked, clamped_checked, maps_loaded);
        $display("settings spanned stop counts out of range and writes to unused indexes");
        if (errors == 0 && pending == 0)
            $display("tb_colormap_interpolate_lookup: done, clean");
        else
            $display("tb_colormap_interpolate_lookup: done, errors");
        $finish;
    end

endmodule
